/* src/wsfp_pkg.sv */
package wsfp_pkg;

  // Frame status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR   = 3'd1;
  localparam logic [2:0] ST_RSV_BITS    = 3'd2;
  localparam logic [2:0] ST_SHORT_EXT   = 3'd3;
  localparam logic [2:0] ST_NO_MASK     = 3'd4;
  localparam logic [2:0] ST_SHORT_KEY   = 3'd5;
  localparam logic [2:0] ST_SHORT_PAY   = 3'd6;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd7;

  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } in_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        frame_done;
    logic [2:0]  status;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic [63:0] payload_size;
  } out_t;

endpackage

/* src/websocket_frame_parse_unmask.sv */
// Client WebSocket frame parser and unmasker. Feed one raw byte of the
// received buffer per input transaction, with buffer_end set on the last
// byte of the buffer. The block decodes FIN, opcode, MASK and the 7, 16 or
// 64 bit length, captures the 4-byte masking key and returns each payload
// byte XORed with key byte (index mod 4). Header and key bytes give no
// result unless they end the frame; every frame ends in exactly one result
// with frame_done set and a status (0 ok, 1 short header, 2 reserved bits,
// 3 short ext length, 4 no mask, 5 short key, 6 short payload, 7 too large).
// Discard the payload bytes of a frame whose final status is not ok. Frames
// longer than max_payload_bytes are counted through without payload output
// and end with status 7. Bytes after completion or an error are dropped up
// to buffer_end, which always restarts parsing. Rate: one byte per cycle
// while in_stall is low; each byte is decoded combinationally while it is
// offered, and its result is captured at the accepting edge into the head
// entry, or into the skid entry while the head is held. A two-entry output
// buffer keeps input flowing while one result waits; in_stall rises only when
// both entries are held. cfg_ready is always high; write only while idle.
module websocket_frame_parse_unmask (
  input  logic           clk,
  input  logic           rst_n,
  // byte input channel
  input  logic           in_valid,
  output logic           in_stall,
  input  wsfp_pkg::in_t  in_data,
  // result channel
  output logic           out_valid,
  input  logic           out_stall,
  output wsfp_pkg::out_t out_data,
  // max_payload_bytes write port
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data
);

  logic [31:0]    max_r;
  logic           accept;
  logic           pop;
  wsfp_pkg::out_t res;
  logic           res_valid;
  logic           push;

  // output register and skid entry
  logic           o_valid_r;
  wsfp_pkg::out_t o_data_r;
  logic           s_valid_r;
  wsfp_pkg::out_t s_data_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = s_valid_r;
  assign accept    = in_valid && !s_valid_r;
  assign pop       = o_valid_r && !out_stall;
  assign push      = accept && res_valid;
  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= wsfp_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_r <= cfg_data;
    end
  end

  wsfp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_data     (in_data),
    .max_payload (max_r),
    .res         (res),
    .res_valid   (res_valid)
  );

  // Two-entry result queue: o is the head, s the skid behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (s_valid_r) begin
          o_valid_r <= 1'b1;
          s_valid_r <= push;
        end else begin
          o_valid_r <= push;
        end
      end else if (!o_valid_r) begin
        o_valid_r <= push;
      end else if (push) begin
        s_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (s_valid_r) begin
        o_data_r <= s_data_r;
        if (push) begin
          s_data_r <= res;
        end
      end else if (push) begin
        o_data_r <= res;
      end
    end else if (!o_valid_r) begin
      if (push) begin
        o_data_r <= res;
      end
    end else if (push) begin
      s_data_r <= res;
    end
  end

endmodule

/* src/wsfp_parse.sv */
module wsfp_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  wsfp_pkg::in_t   in_data,
  input  logic [31:0]     max_payload,
  output wsfp_pkg::out_t  res,
  output logic            res_valid
);

  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_EXT16   = 3'd2;
  localparam logic [2:0] PH_EXT64   = 3'd3;
  localparam logic [2:0] PH_KEY     = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_IGNORE  = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_r, mask_nxt;
  logic [63:0] len_r, len_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [31:0] key_r, key_nxt;
  logic [63:0] idx_r, idx_nxt;
  logic        over_r, over_nxt;

  logic [7:0]  b;
  logic        last_in;
  logic [6:0]  len7;
  logic        size_known;
  logic [7:0]  kb;
  logic [63:0] idx_inc;
  logic        pay_last;
  logic [2:0]  hcnt_inc;

  assign b        = in_data.in_byte;
  assign last_in  = in_data.buffer_end;
  assign len7     = b[6:0];
  assign idx_inc  = idx_r + 64'd1;
  assign pay_last = (idx_inc == len_r);
  assign hcnt_inc = hcnt_r + 3'd1;

  always_comb begin
    case (idx_r[1:0])
      2'd0:    kb = key_r[31:24];
      2'd1:    kb = key_r[23:16];
      2'd2:    kb = key_r[15:8];
      default: kb = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    hcnt_nxt   = hcnt_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    over_nxt   = over_r;
    res        = '0;
    res_valid  = 1'b0;
    size_known = 1'b0;

    case (phase_r)
      PH_FIRST: begin
        if (last_in) begin
          res_valid      = 1'b1;
          res.frame_done = 1'b1;
          res.status     = wsfp_pkg::ST_SHORT_HDR;
        end else begin
          fin_nxt    = b[7];
          opcode_nxt = b[3:0];
          if (b[6:4] != 3'd0) begin
            res_valid      = 1'b1;
            res.frame_done = 1'b1;
            res.status     = wsfp_pkg::ST_RSV_BITS;
            phase_nxt      = PH_IGNORE;
          end else begin
            phase_nxt = PH_SECOND;
          end
        end
      end
      PH_SECOND: begin
        mask_nxt = b[7];
        hcnt_nxt = 3'd0;
        if (len7 == 7'd126 || len7 == 7'd127) begin
          len_nxt = '0;
          if (last_in) begin
            res_valid      = 1'b1;
            res.frame_done = 1'b1;
            res.status     = wsfp_pkg::ST_SHORT_EXT;
          end else begin
            phase_nxt = (len7 == 7'd126) ? PH_EXT16 : PH_EXT64;
          end
        end else begin
          len_nxt    = {57'd0, len7};
          size_known = 1'b1;
          if (!b[7]) begin
            res_valid      = 1'b1;
            res.frame_done = 1'b1;
            res.status     = wsfp_pkg::ST_NO_MASK;
            phase_nxt      = PH_IGNORE;
          end else if (last_in) begin
            res_valid      = 1'b1;
            res.frame_done = 1'b1;
            res.status     = wsfp_pkg::ST_SHORT_KEY;
          end else begin
            phase_nxt = PH_KEY;
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_nxt  = {len_r[55:0], b};
        hcnt_nxt = hcnt_inc;
        // 64-bit length: 3-bit count wraps to zero after eight bytes
        if (hcnt_inc == ((phase_r == PH_EXT16) ? 3'd2 : 3'd0)) begin
          hcnt_nxt   = 3'd0;
          size_known = 1'b1;
          if (!mask_r) begin
            res_valid      = 1'b1;
            res.frame_done = 1'b1;
            res.status     = wsfp_pkg::ST_NO_MASK;
            phase_nxt      = PH_IGNORE;
          end else if (last_in) begin
            res_valid      = 1'b1;
            res.frame_done = 1'b1;
            res.status     = wsfp_pkg::ST_SHORT_KEY;
          end else begin
            phase_nxt = PH_KEY;
          end
        end else if (last_in) begin
          res_valid      = 1'b1;
          res.frame_done = 1'b1;
          res.status     = wsfp_pkg::ST_SHORT_EXT;
        end
      end
      PH_KEY: begin
        key_nxt    = {key_r[23:0], b};
        hcnt_nxt   = hcnt_inc;
        size_known = 1'b1;
        if (hcnt_inc == 3'd4) begin
          hcnt_nxt = 3'd0;
          idx_nxt  = '0;
          over_nxt = (len_r > {32'd0, max_payload});
          if (len_r == 64'd0) begin
            res_valid      = 1'b1;
            res.frame_done = 1'b1;
            res.status     = over_nxt ? wsfp_pkg::ST_TOO_LARGE : wsfp_pkg::ST_OK;
            phase_nxt      = PH_IGNORE;
          end else if (last_in) begin
            res_valid      = 1'b1;
            res.frame_done = 1'b1;
            res.status     = wsfp_pkg::ST_SHORT_PAY;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end else if (last_in) begin
          res_valid      = 1'b1;
          res.frame_done = 1'b1;
          res.status     = wsfp_pkg::ST_SHORT_KEY;
        end
      end
      PH_PAYLOAD: begin
        size_known = 1'b1;
        idx_nxt    = idx_inc;
        if (pay_last) begin
          res_valid        = 1'b1;
          res.frame_done   = 1'b1;
          res.byte_valid   = !over_r;
          res.payload_byte = over_r ? 8'd0 : (b ^ kb);
          res.status       = over_r ? wsfp_pkg::ST_TOO_LARGE : wsfp_pkg::ST_OK;
          phase_nxt        = PH_IGNORE;
        end else if (last_in) begin
          res_valid      = 1'b1;
          res.frame_done = 1'b1;
          res.status     = wsfp_pkg::ST_SHORT_PAY;
        end else if (!over_r) begin
          res_valid        = 1'b1;
          res.byte_valid   = 1'b1;
          res.payload_byte = b ^ kb;
        end
      end
      default: begin
      end
    endcase

    res.fin_flag     = fin_nxt;
    res.frame_opcode = opcode_nxt;
    res.payload_size = size_known ? len_nxt : 64'd0;

    if (last_in) begin
      phase_nxt  = PH_FIRST;
      fin_nxt    = 1'b0;
      opcode_nxt = '0;
      mask_nxt   = 1'b0;
      len_nxt    = '0;
      hcnt_nxt   = '0;
      key_nxt    = '0;
      idx_nxt    = '0;
      over_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      fin_r    <= 1'b0;
      opcode_r <= '0;
      mask_r   <= 1'b0;
      len_r    <= '0;
      hcnt_r   <= '0;
      key_r    <= '0;
      idx_r    <= '0;
      over_r   <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      hcnt_r   <= hcnt_nxt;
      key_r    <= key_nxt;
      idx_r    <= idx_nxt;
      over_r   <= over_nxt;
    end
  end

endmodule
